/* sv/ccrss_pkg.sv */
package ccrss_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_SET_CUR = 2'd1;
  localparam logic [1:0] OP_REQUEST = 2'd2;

  localparam logic [1:0] RSN_GOV = 2'd0;
  localparam logic [1:0] RSN_WFI = 2'd1;
  localparam logic [1:0] RSN_PC  = 2'd2;

  localparam logic [2:0] K_ACK     = 3'd0;
  localparam logic [2:0] K_VDD     = 3'd1;
  localparam logic [2:0] K_BUS     = 3'd2;
  localparam logic [2:0] K_PLL_ON  = 3'd3;
  localparam logic [2:0] K_PROG    = 3'd4;
  localparam logic [2:0] K_PLL_OFF = 3'd5;
  localparam logic [2:0] K_FINISH  = 3'd6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNKNOWN   = 3'd1;
  localparam logic [2:0] ST_VDD_FAIL  = 3'd2;
  localparam logic [2:0] ST_BUS_FAIL  = 3'd3;
  localparam logic [2:0] ST_UNINIT    = 3'd4;
  localparam logic [2:0] ST_BAD_ENTRY = 3'd5;

  localparam int VDD_BASE_MV   = 750;
  localparam int VDD_STEP_MV   = 25;
  localparam int VDD_MAX_STEPS = 'h3F;
  localparam int VDD_TAG       = 7;
  localparam int VDD_RECIP       = 1311;
  localparam int VDD_RECIP_SHIFT = 15;
  localparam logic [11:0] VDD_CLAMP_X = 12'((VDD_MAX_STEPS + 1) * VDD_STEP_MV);

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         index;
    logic [20:0]        entry_rate_khz;
    logic signed [3:0]  entry_source;
    logic [2:0]         entry_mux_select;
    logic [3:0]         entry_divider;
    logic [17:0]        entry_bus_khz;
    logic [11:0]        entry_vdd_mv;
    logic [20:0]        target_rate_khz;
    logic [1:0]         reason;
    logic               vdd_fail;
    logic               bus_fail;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [17:0] value;
    logic        mux_side;
    logic [2:0]  status;
    logic [20:0] current_rate_khz;
    logic        last;
  } out_res_t;

  typedef struct packed {
    logic [20:0]        rate;
    logic signed [3:0]  src;
    logic [2:0]         sel;
    logic [3:0]         div;
    logic [17:0]        bus;
    logic [11:0]        mv;
  } point_t;

  // Steps of 25 mV above 750 mV, clamped to 63, tagged with 0xE0.
  // Division by 25 uses a reciprocal that is exact below the clamp point.
  function automatic logic [7:0] vdd_word(input logic [11:0] mv);
    logic [11:0] x;
    logic [21:0] prod;
    logic [5:0]  steps;
    x     = mv - 12'(VDD_BASE_MV);
    prod  = 22'(x[10:0]) * 22'(VDD_RECIP);
    if (mv < 12'(VDD_BASE_MV)) begin
      steps = '0;
    end else if (x >= VDD_CLAMP_X) begin
      steps = 6'(VDD_MAX_STEPS);
    end else begin
      steps = prod[VDD_RECIP_SHIFT +: 6];
    end
    return {2'b00, steps} | {3'(VDD_TAG), 5'b00000};
  endfunction

endpackage

/* sv/ccrss_table.sv */
module ccrss_table
  import ccrss_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int AW = $clog2(TABLE_ENTRIES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic          rd_en,
  input  logic [AW-1:0] addr,
  input  point_t        wdata,
  output point_t        rdata
);

  point_t                   mem_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld_r;
  point_t                   mem_q_r;
  logic                     vld_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q_r <= vld_r[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[addr] <= wdata;
    end
    if (rd_en) begin
      mem_q_r <= mem_r[addr];
    end
  end

  // An entry never written since reset reads as all zero.
  assign rdata = vld_q_r ? mem_q_r : '0;

endmodule

/* sv/ccrss_ctrl.sv */
module ccrss_ctrl
  import ccrss_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int AW = $clog2(TABLE_ENTRIES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_req_t       in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output out_res_t      out_data,
  output logic          tbl_wr_en,
  output logic          tbl_rd_en,
  output logic [AW-1:0] tbl_addr,
  output point_t        tbl_wdata,
  input  point_t        tbl_rdata
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ONE    = 4'd1;
  localparam logic [3:0] S_SC_RD  = 4'd2;
  localparam logic [3:0] S_SC_CHK = 4'd3;
  localparam logic [3:0] S_RQ_ST  = 4'd4;
  localparam logic [3:0] S_RQ_STW = 4'd5;
  localparam logic [3:0] S_RQ_RD  = 4'd6;
  localparam logic [3:0] S_RQ_CHK = 4'd7;
  localparam logic [3:0] S_PLAN   = 4'd8;
  localparam logic [3:0] S_SEQ    = 4'd9;

  localparam logic [2:0] STEP_VUP  = 3'd0;
  localparam logic [2:0] STEP_BUP  = 3'd1;
  localparam logic [2:0] STEP_PON  = 3'd2;
  localparam logic [2:0] STEP_PROG = 3'd3;
  localparam logic [2:0] STEP_POFF = 3'd4;
  localparam logic [2:0] STEP_BDN  = 3'd5;
  localparam logic [2:0] STEP_VDN  = 3'd6;
  localparam logic [2:0] STEP_FIN  = 3'd7;

  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

  logic [3:0]    state_r, state_nxt;
  in_req_t       req_r, req_nxt;
  logic [AW-1:0] idx_i_r, idx_i_nxt;
  logic [AW-1:0] cur_entry_r, cur_entry_nxt;
  logic          cur_valid_r, cur_valid_nxt;
  logic [20:0]   cur_rate_r, cur_rate_nxt;
  logic          mux_r, mux_nxt;
  logic [15:0]   shadow_r, shadow_nxt;
  point_t        st_r, st_nxt;
  point_t        tg_r, tg_nxt;
  logic [AW-1:0] found_r, found_nxt;
  logic [2:0]    step_r, step_nxt;
  logic [2:0]    fin_status_r, fin_status_nxt;
  logic [2:0]    one_kind_r, one_kind_nxt;
  logic [20:0]   step_rate_r, step_rate_nxt;
  logic [7:0]    vword_r, vword_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_res_t      out_data_r, out_data_nxt;

  logic          in_acc;
  logic          emit_ok;
  logic          idx_ok;
  logic [AW-1:0] in_addr;
  logic [20:0]   cur_rate_out;
  logic          gov;
  logic          wfi;
  logic          vup;
  logic          bup;
  logic          src_diff;
  logic [7:0]    half_byte;
  logic [15:0]   ctl;
  logic          apply;
  logic          fail;
  logic [2:0]    fail_status;
  logic [2:0]    cmd_kind;
  logic [17:0]   cmd_value;
  logic          cmd_side;

  assign in_ready     = (state_r == S_IDLE);
  assign in_acc       = in_valid && in_ready;
  assign emit_ok      = !out_valid_r || out_ready;
  assign idx_ok       = int'(in_data.index) < TABLE_ENTRIES;
  assign in_addr      = AW'(in_data.index);
  assign cur_rate_out = cur_valid_r ? cur_rate_r : '0;
  assign gov          = (req_r.reason != RSN_WFI) && (req_r.reason != RSN_PC);
  assign wfi          = (req_r.reason == RSN_WFI);
  assign vup          = gov && (tg_r.mv > st_r.mv);
  assign bup          = tg_r.bus > st_r.bus;
  assign src_diff     = st_r.src != tg_r.src;
  assign half_byte    = {1'b0, tg_r.sel, tg_r.div};
  assign ctl          = mux_r ? {half_byte, shadow_r[7:0]} : {shadow_r[15:8], half_byte};

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    apply       = 1'b0;
    fail        = 1'b0;
    fail_status = ST_OK;
    cmd_kind    = K_FINISH;
    cmd_value   = '0;
    cmd_side    = 1'b0;
    unique case (step_r)
      STEP_VUP: begin
        apply       = vup;
        cmd_kind    = K_VDD;
        cmd_value   = 18'(vword_r);
        fail        = req_r.vdd_fail;
        fail_status = ST_VDD_FAIL;
      end
      STEP_BUP: begin
        apply       = bup;
        cmd_kind    = K_BUS;
        cmd_value   = tg_r.bus;
        fail        = req_r.bus_fail;
        fail_status = ST_BUS_FAIL;
      end
      STEP_PON: begin
        apply     = src_diff && !tg_r.src[3];
        cmd_kind  = K_PLL_ON;
        cmd_value = 18'(tg_r.src[2:0]);
      end
      STEP_PROG: begin
        apply     = 1'b1;
        cmd_kind  = K_PROG;
        cmd_value = 18'(ctl);
        cmd_side  = !mux_r;
      end
      STEP_POFF: begin
        apply     = !wfi && src_diff && !st_r.src[3];
        cmd_kind  = K_PLL_OFF;
        cmd_value = 18'(st_r.src[2:0]);
      end
      STEP_BDN: begin
        apply     = !wfi && (tg_r.bus < st_r.bus);
        cmd_kind  = K_BUS;
        cmd_value = tg_r.bus;
      end
      STEP_VDN: begin
        apply     = gov && (tg_r.mv < st_r.mv);
        cmd_kind  = K_VDD;
        cmd_value = 18'(vword_r);
      end
      default: begin
        apply = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    idx_i_nxt      = idx_i_r;
    cur_entry_nxt  = cur_entry_r;
    cur_valid_nxt  = cur_valid_r;
    cur_rate_nxt   = cur_rate_r;
    mux_nxt        = mux_r;
    shadow_nxt     = shadow_r;
    st_nxt         = st_r;
    tg_nxt         = tg_r;
    found_nxt      = found_r;
    step_nxt       = step_r;
    fin_status_nxt = fin_status_r;
    one_kind_nxt   = one_kind_r;
    step_rate_nxt  = step_rate_r;
    vword_nxt      = vword_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    tbl_wr_en      = 1'b0;
    tbl_rd_en      = 1'b0;
    tbl_addr       = idx_i_r;
    tbl_wdata      = '{rate: in_data.entry_rate_khz, src: in_data.entry_source,
                       sel: in_data.entry_mux_select, div: in_data.entry_divider,
                       bus: in_data.entry_bus_khz, mv: in_data.entry_vdd_mv};

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt        = in_data;
          step_rate_nxt  = cur_rate_out;
          one_kind_nxt   = K_ACK;
          fin_status_nxt = ST_OK;
          idx_i_nxt      = '0;
          unique case (in_data.op)
            OP_WRITE: begin
              state_nxt = S_ONE;
              if (idx_ok) begin
                tbl_wr_en = 1'b1;
                tbl_addr  = in_addr;
                if (cur_valid_r && (cur_entry_r == in_addr)) begin
                  cur_rate_nxt  = in_data.entry_rate_khz;
                  step_rate_nxt = in_data.entry_rate_khz;
                end
              end else begin
                fin_status_nxt = ST_BAD_ENTRY;
              end
            end
            OP_SET_CUR: begin
              if (idx_ok) begin
                state_nxt = S_SC_RD;
              end else begin
                fin_status_nxt = ST_BAD_ENTRY;
                state_nxt      = S_ONE;
              end
            end
            OP_REQUEST: begin
              one_kind_nxt = K_FINISH;
              if (cur_valid_r) begin
                state_nxt = S_RQ_ST;
              end else begin
                fin_status_nxt = ST_UNINIT;
                state_nxt      = S_ONE;
              end
            end
            default: begin
              state_nxt = S_ONE;
            end
          endcase
        end
      end
      S_SC_RD: begin
        tbl_rd_en = 1'b1;
        state_nxt = S_SC_CHK;
      end
      S_SC_CHK: begin
        if (tbl_rdata.rate == '0) begin
          fin_status_nxt = ST_BAD_ENTRY;
          state_nxt      = S_ONE;
        end else if (idx_i_r == AW'(req_r.index)) begin
          cur_entry_nxt = idx_i_r;
          cur_valid_nxt = 1'b1;
          cur_rate_nxt  = tbl_rdata.rate;
          step_rate_nxt = tbl_rdata.rate;
          state_nxt     = S_ONE;
        end else begin
          idx_i_nxt = idx_i_r + 1'b1;
          state_nxt = S_SC_RD;
        end
      end
      S_RQ_ST: begin
        tbl_rd_en = 1'b1;
        tbl_addr  = cur_entry_r;
        state_nxt = S_RQ_STW;
      end
      S_RQ_STW: begin
        st_nxt = tbl_rdata;
        if (req_r.target_rate_khz == tbl_rdata.rate) begin
          state_nxt = S_ONE;
        end else begin
          state_nxt = S_RQ_RD;
        end
      end
      S_RQ_RD: begin
        tbl_rd_en = 1'b1;
        state_nxt = S_RQ_CHK;
      end
      S_RQ_CHK: begin
        if (tbl_rdata.rate == '0) begin
          fin_status_nxt = ST_UNKNOWN;
          state_nxt      = S_ONE;
        end else if (tbl_rdata.rate == req_r.target_rate_khz) begin
          tg_nxt    = tbl_rdata;
          found_nxt = idx_i_r;
          state_nxt = S_PLAN;
        end else if (idx_i_r == LAST_IDX) begin
          fin_status_nxt = ST_UNKNOWN;
          state_nxt      = S_ONE;
        end else begin
          idx_i_nxt = idx_i_r + 1'b1;
          state_nxt = S_RQ_RD;
        end
      end
      S_PLAN: begin
        vword_nxt = vdd_word(tg_r.mv);
        if ((vup && req_r.vdd_fail) || (bup && req_r.bus_fail)) begin
          step_rate_nxt = cur_rate_out;
        end else begin
          step_rate_nxt = tg_r.rate;
        end
        step_nxt  = STEP_VUP;
        state_nxt = S_SEQ;
      end
      S_SEQ: begin
        if (step_r == STEP_FIN) begin
          state_nxt = S_ONE;
        end else if (!apply) begin
          step_nxt = step_r + 1'b1;
        end else if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{kind: cmd_kind, value: cmd_value, mux_side: cmd_side,
                            status: ST_OK, current_rate_khz: step_rate_r, last: 1'b0};
          if (fail) begin
            fin_status_nxt = fail_status;
            step_nxt       = STEP_FIN;
          end else if ((step_r == STEP_PROG) && wfi) begin
            step_nxt = STEP_FIN;
          end else begin
            step_nxt = step_r + 1'b1;
          end
          if (step_r == STEP_PROG) begin
            shadow_nxt    = ctl;
            mux_nxt       = !mux_r;
            cur_entry_nxt = found_r;
            cur_rate_nxt  = tg_r.rate;
          end
        end
      end
      S_ONE: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{kind: one_kind_r, value: '0, mux_side: 1'b0,
                            status: fin_status_r, current_rate_khz: step_rate_r,
                            last: 1'b1};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cur_entry_r  <= '0;
      cur_valid_r  <= 1'b0;
      cur_rate_r   <= '0;
      mux_r        <= 1'b0;
      shadow_r     <= '0;
      step_r       <= STEP_VUP;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_entry_r  <= cur_entry_nxt;
      cur_valid_r  <= cur_valid_nxt;
      cur_rate_r   <= cur_rate_nxt;
      mux_r        <= mux_nxt;
      shadow_r     <= shadow_nxt;
      step_r       <= step_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    idx_i_r      <= idx_i_nxt;
    st_r         <= st_nxt;
    tg_r         <= tg_nxt;
    found_r      <= found_nxt;
    fin_status_r <= fin_status_nxt;
    one_kind_r   <= one_kind_nxt;
    step_rate_r  <= step_rate_nxt;
    vword_r      <= vword_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

/* sv/cpu_clock_rate_switch_sequencer_core.sv */
// Rate-switch sequencer for a core clock. The operating-point table lives in a
// single-port synchronous memory with per-entry valid bits, so it reads as all
// zero right after reset with no clearing pass. One request is handled at a time
// and in_ready is high only between requests; results leave through an output
// register, so the next request is taken while the final result still waits.
// A table write is taken in S_IDLE and its ack leaves from S_ONE through the
// output register. Setting the current entry scans the table from entry 0,
// each entry through a read state and a check state. A rate request reads the
// current entry and then searches the table from entry 0 the same way, followed
// by a planning state and the command steps of the sequence state, where a
// command waits while the result side stalls.
module cpu_clock_rate_switch_sequencer_core
  import ccrss_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_res_t out_data
);

  localparam int AW = $clog2(TABLE_ENTRIES);

  logic          tbl_wr_en;
  logic          tbl_rd_en;
  logic [AW-1:0] tbl_addr;
  point_t        tbl_wdata;
  point_t        tbl_rdata;

  ccrss_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .rst_n(rst_n),
    .wr_en(tbl_wr_en),
    .rd_en(tbl_rd_en),
    .addr (tbl_addr),
    .wdata(tbl_wdata),
    .rdata(tbl_rdata)
  );

  ccrss_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .tbl_wr_en(tbl_wr_en),
    .tbl_rd_en(tbl_rd_en),
    .tbl_addr (tbl_addr),
    .tbl_wdata(tbl_wdata),
    .tbl_rdata(tbl_rdata)
  );

endmodule

/* sv/ccrss_checker.sv */
module ccrss_checker
  import ccrss_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input out_res_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_cmd_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind != K_ACK) && (out_data.kind != K_FINISH)
      |-> (out_data.status == ST_OK) && !out_data.last)
    else $error("command result with nonzero status or marked last");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.kind == K_ACK) || (out_data.kind == K_FINISH))
      |-> out_data.last && (out_data.value == '0))
    else $error("ack or finish not final or with a value");

  a_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind != K_PROG) |-> !out_data.mux_side)
    else $error("mux side set outside a clock program command");

  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken before the first was finished");

endmodule

bind cpu_clock_rate_switch_sequencer_core ccrss_checker u_ccrss_checker (.*);
